// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the display driver RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define MSSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define MSSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: sv/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Types, codes and the segment decode shared by the display driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

    localparam int NUM_DIGITS_DEF = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] SWITCH_PERIOD_RST = 16'd1000;
    localparam logic [7:0]  BLINK_RELOAD_RST  = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_RELOAD  = 1'd1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_DIGIT = 2'd1,
        CMD_MODE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_KEEP  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] switch_period;
        logic [7:0]  blink_reload;
    } t_cfg;

    typedef struct packed {
        t_cmd        command;
        logic [1:0]  display_index;
        logic [3:0]  digit_value;
        t_mode       display_mode;
    } t_item;

    typedef struct packed {
        logic [1:0] active_display;
        logic [6:0] segments;
        logic       switched;
    } t_result;

    // Decimal digit to segment lines, bit0 = a ... bit6 = g; others blank
    function automatic logic [6:0] seg_decode(input logic [3:0] v);
        logic [6:0] seg;
        case (v)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: sv/mssd_item_if.sv
// ----------------------------------------------------------------------------
// mssd_item_if
// Command channel: tick, digit value write or display mode write.
// ----------------------------------------------------------------------------
interface mssd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] display_index;
    logic [3:0] digit_value;
    logic [1:0] display_mode;

    modport source (
        output valid, command, display_index, digit_value, display_mode,
        input  ready
    );
    modport sink (
        input  valid, command, display_index, digit_value, display_mode,
        output ready
    );
endinterface

// File: sv/mssd_result_if.sv
// ----------------------------------------------------------------------------
// mssd_result_if
// Result channel: active digit, latched segments and rotation flag.
// ----------------------------------------------------------------------------
interface mssd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] active_display;
    logic [6:0] segments;
    logic       switched;

    modport source (
        output valid, active_display, segments, switched,
        input  ready
    );
    modport sink (
        input  valid, active_display, segments, switched,
        output ready
    );
endinterface

// File: sv/mssd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mssd_cfg_regs
// Switch period and blink reload registers behind a plain write port.
// ----------------------------------------------------------------------------
module mssd_cfg_regs
    import mssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Decode the index and load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_period <= SWITCH_PERIOD_RST;
            r_cfg.blink_reload  <= BLINK_RELOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SWITCH_PERIOD: r_cfg.switch_period <= i_cfg_data;
                REG_BLINK_RELOAD:  r_cfg.blink_reload  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/mssd_engine.sv
// ----------------------------------------------------------------------------
// mssd_engine
// Display state: tick counter, digit rotation, per-digit stores, blink
// counters and the segment latch. Forms the result of the item on hand.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mssd_engine
    import mssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [DW-1:0] LAST_DIGIT = DW'(NUM_DIGITS - 1);

    logic [15:0]   r_tick_count;
    logic [DW-1:0] r_cur;
    logic [3:0]    r_digit_store [NUM_DIGITS];
    t_mode         r_mode_store  [NUM_DIGITS];
    logic          r_lit         [NUM_DIGITS];
    logic [7:0]    r_blink       [NUM_DIGITS];
    logic [6:0]    r_latch;

    logic [15:0]   n_tick_count;
    logic [DW-1:0] n_cur;
    logic          n_lit;
    logic [7:0]    n_blink;
    logic [6:0]    n_latch;

    logic          w_rotate;
    logic [DW+1:0] w_idx_ext;
    logic [DW+1:0] w_cur_ext;
    logic          w_idx_ok;
    logic [DW-1:0] w_idx;
    logic          w_wr_digit;
    logic          w_wr_mode;

    // Advance the tick counter and decide on a rotation
    always_comb begin
        logic [15:0] tick_inc;
        tick_inc     = r_tick_count + 16'd1;
        w_rotate     = (i_item.command == CMD_TICK) && (tick_inc >= i_cfg.switch_period);
        n_tick_count = w_rotate ? 16'd0 : tick_inc;
        n_cur        = (r_cur == LAST_DIGIT) ? '0 : r_cur + DW'(1);
    end

    // Refresh the flag of the digit that becomes active, then decode it
    always_comb begin
        n_lit   = r_lit[n_cur];
        n_blink = r_blink[n_cur];
        case (r_mode_store[n_cur])
            MODE_OFF: n_lit = 1'b0;
            MODE_ON:  n_lit = 1'b1;
            MODE_BLINK: begin
                if (r_blink[n_cur] == 8'd0) begin
                    n_lit   = ~r_lit[n_cur];
                    n_blink = i_cfg.blink_reload;
                end else begin
                    n_blink = r_blink[n_cur] - 8'd1;
                end
            end
            default: ;
        endcase
        n_latch = n_lit ? seg_decode(r_digit_store[n_cur]) : 7'h00;
    end

    // Range-check the write index against the digit count
    assign w_idx_ext  = {{DW{1'b0}}, i_item.display_index};
    assign w_idx_ok   = w_idx_ext < (DW + 2)'(NUM_DIGITS);
    assign w_idx      = w_idx_ext[DW-1:0];
    assign w_wr_digit = (i_item.command == CMD_DIGIT) && w_idx_ok;
    assign w_wr_mode  = (i_item.command == CMD_MODE) && w_idx_ok;

    // Hold state, update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_cur        <= '0;
            r_latch      <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit_store[i] <= '0;
                r_mode_store[i]  <= MODE_ON;
                r_lit[i]         <= 1'b1;
                r_blink[i]       <= '0;
            end
        end else if (i_adv) begin
            if (i_item.command == CMD_TICK) begin
                r_tick_count <= n_tick_count;
            end
            if (w_rotate) begin
                r_cur          <= n_cur;
                r_lit[n_cur]   <= n_lit;
                r_blink[n_cur] <= n_blink;
                r_latch        <= n_latch;
            end
            if (w_wr_digit) begin
                r_digit_store[w_idx] <= i_item.digit_value;
            end
            if (w_wr_mode) begin
                r_mode_store[w_idx] <= i_item.display_mode;
            end
        end
    end

    // Result of the item on hand
    always_comb begin
        w_cur_ext                = {2'b00, (w_rotate ? n_cur : r_cur)};
        o_result.active_display  = w_cur_ext[1:0];
        o_result.segments        = w_rotate ? n_latch : r_latch;
        o_result.switched        = w_rotate;
    end

    `MSSD_ASSERT(a_switch_only_on_tick, w_rotate |-> (i_item.command == CMD_TICK), "rotation without tick")
    `MSSD_ASSERT(a_tick_clears, (i_adv && w_rotate) |=> (r_tick_count == 16'd0), "tick counter not cleared")
    `MSSD_ASSERT(a_digit_in_range, ({2'b00, r_cur} < (DW + 2)'(NUM_DIGITS)), "active digit out of range")
    `MSSD_ASSERT(a_dark_blank, (i_adv && w_rotate && !n_lit) |=> (r_latch == 7'h00), "dark digit lit")

endmodule

// File: sv/multiplexed_seven_segment_blink_driver_core.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_blink_driver_core
// Multiplexed seven-segment display driver with per-digit blinking.
// ----------------------------------------------------------------------------
// Every command (tick, digit write or mode write) yields one result: the
// active digit, the latched segment lines and a flag telling whether this
// command rotated the display. One command is taken every clock cycle while
// the input is not stalled; a command passes an input register and is then
// applied to the display state while its result is loaded into the output
// register. Backpressure on the result side stalls the input only once
// both registers are full. There is no clearing pass after reset. The
// switch period and blink reload registers are written through the
// configuration port; the user must write them only while no command is
// in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiplexed_seven_segment_blink_driver_core
    import mssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mssd_item_if.sink             i_item,
    mssd_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_adv;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    mssd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mssd_engine #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_adv    (w_adv),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // Move the held command on when the output register is free or being emptied
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.command       <= t_cmd'(i_item.command);
            r_item.display_index <= i_item.display_index;
            r_item.digit_value   <= i_item.digit_value;
            r_item.display_mode  <= t_mode'(i_item.display_mode);
        end
    end

    // Output register: load on advance, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.active_display = r_result.active_display;
    assign o_result.segments       = r_result.segments;
    assign o_result.switched       = r_result.switched;

    `MSSD_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `MSSD_ASSERT(a_held_item_kept, (r_in_valid && !w_adv) |=> r_in_valid, "held command lost")
    `MSSD_ASSERT(a_adv_fills_out, w_adv |=> r_out_valid, "advance without result")

endmodule
